>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

>>> rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// types, constants and helper functions of the i2c master bit sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // width of the occupancy counter and of the timing registers
    localparam int CountWidth = 16;
    localparam int StepWidth  = 5;

    localparam logic [CountWidth-1:0] HoldReset   = CountWidth'(20);
    localparam logic [CountWidth-1:0] SampleReset = CountWidth'(1);
    localparam logic [7:0]            MsbMask     = 8'h80;

    // configuration register indexes
    localparam logic REG_HOLD   = 1'b0;
    localparam logic REG_SAMPLE = 1'b1;

    // line commands
    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_SACK  = 3'd4,
        OP_RACK  = 3'd5
    } t_op;

    // input word
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic       sda_in;
    } t_in_word;

    // result word
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } t_out_word;

    // line state carried through one action
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       ack;
        logic [7:0] shift;
    } t_line;

    // outcome of one action
    typedef struct packed {
        t_line                 line;
        logic [CountWidth-1:0] delay;
    } t_act;

    // number of actions in each command sequence
    function automatic logic [StepWidth-1:0] seq_len(input t_op op);
        logic [StepWidth-1:0] len;
        case (op)
            OP_START: len = StepWidth'(4);
            OP_STOP:  len = StepWidth'(3);
            OP_WRITE: len = StepWidth'(24);
            OP_READ:  len = StepWidth'(25);
            OP_SACK:  len = StepWidth'(3);
            default:  len = StepWidth'(4);
        endcase
        return len;
    endfunction

    // remainder by three of a step index, by subtracting multiples of three
    function automatic logic [1:0] mod3(input logic [StepWidth-1:0] x);
        logic [StepWidth-1:0] v;
        v = x;
        if (v >= StepWidth'(24)) v = v - StepWidth'(24);
        if (v >= StepWidth'(12)) v = v - StepWidth'(12);
        if (v >= StepWidth'(6))  v = v - StepWidth'(6);
        if (v >= StepWidth'(3))  v = v - StepWidth'(3);
        return v[1:0];
    endfunction

endpackage

>>> rtl/i2cms_action.sv
// ----------------------------------------------------------------------------
// i2cms_action
// decodes one line action of a command sequence: pin write or sda sample
// ----------------------------------------------------------------------------
module i2cms_action (
    input  i2cms_pkg::t_op                         i_op,
    input  logic [i2cms_pkg::StepWidth-1:0]        i_step,
    input  i2cms_pkg::t_line                       i_line,
    input  logic                                   i_sda_in,
    input  logic [i2cms_pkg::CountWidth-1:0]       i_pin_delay,
    input  logic [i2cms_pkg::CountWidth-1:0]       i_sample_ticks,
    output i2cms_pkg::t_act                        o_act
);

    logic [1:0] ph_wr;
    logic [1:0] ph_rd;

    // bit phase within a write or a read
    assign ph_wr = i2cms_pkg::mod3(i_step);
    assign ph_rd = i2cms_pkg::mod3(i_step - i2cms_pkg::StepWidth'(1));

    // action decode
    always_comb begin
        o_act.line  = i_line;
        o_act.delay = i_pin_delay;
        unique case (i_op)
            i2cms_pkg::OP_START: begin
                if (i_step == i2cms_pkg::StepWidth'(0))      o_act.line.sda = 1'b1;
                else if (i_step == i2cms_pkg::StepWidth'(1)) o_act.line.scl = 1'b1;
                else if (i_step == i2cms_pkg::StepWidth'(2)) o_act.line.sda = 1'b0;
                else                                         o_act.line.scl = 1'b0;
            end
            i2cms_pkg::OP_STOP: begin
                if (i_step == i2cms_pkg::StepWidth'(0))      o_act.line.sda = 1'b0;
                else if (i_step == i2cms_pkg::StepWidth'(1)) o_act.line.scl = 1'b1;
                else                                         o_act.line.sda = 1'b1;
            end
            i2cms_pkg::OP_WRITE: begin
                if (ph_wr == 2'd0) begin
                    o_act.line.sda = i_line.shift[7];
                end else if (ph_wr == 2'd1) begin
                    o_act.line.scl = 1'b1;
                end else begin
                    o_act.line.scl   = 1'b0;
                    o_act.line.shift = {i_line.shift[6:0], 1'b0};
                end
            end
            i2cms_pkg::OP_READ: begin
                if (i_step == i2cms_pkg::StepWidth'(0)) begin
                    o_act.line.sda = 1'b1;
                end else if (ph_rd == 2'd0) begin
                    o_act.line.scl = 1'b1;
                end else if (ph_rd == 2'd1) begin
                    o_act.line.shift = {i_line.shift[6:0], i_sda_in};
                    o_act.delay      = i_sample_ticks;
                end else begin
                    o_act.line.scl = 1'b0;
                end
            end
            i2cms_pkg::OP_SACK: begin
                if (i_step == i2cms_pkg::StepWidth'(0))      o_act.line.sda = i_line.shift[7];
                else if (i_step == i2cms_pkg::StepWidth'(1)) o_act.line.scl = 1'b1;
                else                                         o_act.line.scl = 1'b0;
            end
            default: begin
                // receive ack
                if (i_step == i2cms_pkg::StepWidth'(0)) begin
                    o_act.line.sda = 1'b1;
                end else if (i_step == i2cms_pkg::StepWidth'(1)) begin
                    o_act.line.scl = 1'b1;
                end else if (i_step == i2cms_pkg::StepWidth'(2)) begin
                    o_act.line.ack = i_sda_in;
                    o_act.delay    = i_sample_ticks;
                end else begin
                    o_act.line.scl = 1'b0;
                end
            end
        endcase
    end

endmodule

>>> rtl/i2c_master_bit_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit
// i2c master line sequencer: one input word is one timing tick
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_in_data  (t_in_word)
//  output    out        o_out_valid / i_out_ready  o_out_data (t_out_word)
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  one word per clock sustained while the result is not stalled; the path runs
//  through an input register, then the sequencer step logic into the result register
//  a stalled result holds the step logic; the input register still takes a
//  word while the result register is empty or being drained
//  synchronous active-low reset clears state to released lines and idle
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  i2cms_pkg::t_in_word                   i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output i2cms_pkg::t_out_word                  o_out_data,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [i2cms_pkg::CountWidth-1:0]      i_cfg_data
);

    localparam int CW = i2cms_pkg::CountWidth;
    localparam int SW = i2cms_pkg::StepWidth;

    // configuration
    logic [CW-1:0] r_hold;
    logic [CW-1:0] r_sample;

    // pipeline registers
    logic                  r_in_valid;
    i2cms_pkg::t_in_word   r_in;
    logic                  r_out_valid;
    i2cms_pkg::t_out_word  r_out;

    // sequencer state
    i2cms_pkg::t_op   r_op;
    logic [SW-1:0]    r_step;
    logic [CW-1:0]    r_wait;
    i2cms_pkg::t_line r_line;
    logic [7:0]       r_rx;
    logic             r_busy;

    // next values
    i2cms_pkg::t_op   n_op;
    logic [SW-1:0]    n_step;
    logic [CW-1:0]    n_wait;
    i2cms_pkg::t_line n_line;
    logic [7:0]       n_rx;
    logic             n_busy;
    logic             n_done;

    logic             advance;
    logic             start;
    logic             run;
    logic [SW-1:0]    step0;
    logic [SW-1:0]    step1;
    i2cms_pkg::t_line line0;
    i2cms_pkg::t_act  act_a;
    i2cms_pkg::t_act  act_b;
    logic [CW-1:0]    pin_delay;

    // handshake
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign pin_delay = (r_hold == '0) ? CW'(1) : r_hold;

    // command launch
    assign start = !r_busy && r_in.cmd_valid && (r_in.opcode <= 3'(i2cms_pkg::OP_RACK));
    assign run   = start || (r_busy && (r_wait == '0));
    assign n_op  = start ? i2cms_pkg::t_op'(r_in.opcode) : r_op;
    assign step0 = start ? SW'(0) : r_step;
    assign step1 = step0 + SW'(1);

    always_comb begin
        line0 = r_line;
        if (start) begin
            if (n_op == i2cms_pkg::OP_WRITE)     line0.shift = r_in.tx_byte;
            else if (n_op == i2cms_pkg::OP_SACK) line0.shift = r_in.ack_level
                                                    ? i2cms_pkg::MsbMask : 8'h00;
            else                                 line0.shift = 8'h00;
        end
    end

    // first action of the tick
    i2cms_action u_act_a (
        .i_op           (n_op),
        .i_step         (step0),
        .i_line         (line0),
        .i_sda_in       (r_in.sda_in),
        .i_pin_delay    (pin_delay),
        .i_sample_ticks (r_sample),
        .o_act          (act_a)
    );

    // follow-up action after a sample that takes no tick
    i2cms_action u_act_b (
        .i_op           (n_op),
        .i_step         (step1),
        .i_line         (act_a.line),
        .i_sda_in       (r_in.sda_in),
        .i_pin_delay    (pin_delay),
        .i_sample_ticks (r_sample),
        .o_act          (act_b)
    );

    // sequencer step
    always_comb begin
        n_step = r_step;
        n_wait = r_wait;
        n_line = r_line;
        n_rx   = r_rx;
        n_busy = r_busy || start;
        if (run) begin
            if (act_a.delay != '0) begin
                n_line = act_a.line;
                n_step = step1;
                n_wait = act_a.delay - CW'(1);
            end else if (step1 < i2cms_pkg::seq_len(n_op)) begin
                n_line = act_b.line;
                n_step = step0 + SW'(2);
                n_wait = (act_b.delay == '0) ? '0 : act_b.delay - CW'(1);
            end else begin
                n_line = act_a.line;
                n_step = step1;
                n_wait = '0;
            end
        end else if (r_busy) begin
            n_wait = r_wait - CW'(1);
        end
        n_done = n_busy && (n_wait == '0) && (n_step >= i2cms_pkg::seq_len(n_op));
        if (n_done) begin
            n_busy = 1'b0;
            if (n_op == i2cms_pkg::OP_READ) n_rx = n_line.shift;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= i2cms_pkg::HoldReset;
            r_sample <= i2cms_pkg::SampleReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                i2cms_pkg::REG_HOLD:   r_hold   <= i_cfg_data;
                i2cms_pkg::REG_SAMPLE: r_sample <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // sequencer state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= i2cms_pkg::OP_START;
            r_step      <= '0;
            r_wait      <= '0;
            r_line      <= '{scl: 1'b1, sda: 1'b1, ack: 1'b0, shift: 8'h00};
            r_rx        <= 8'h00;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_op   <= n_op;
                r_step <= n_step;
                r_wait <= n_wait;
                r_line <= n_line;
                r_rx   <= n_rx;
                r_busy <= n_busy;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.scl_out  <= n_line.scl;
            r_out.sda_out  <= n_line.sda;
            r_out.busy_res <= n_busy;
            r_out.done_res <= n_done;
            r_out.rx_byte  <= n_rx;
            r_out.ack_seen <= n_line.ack;
        end
    end

endmodule

>>> rtl/i2cms_checker.sv
// ----------------------------------------------------------------------------
// i2cms_checker
// port-level checks on the i2c master bit sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cms_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input i2cms_pkg::t_out_word o_out_data
);

    // result held while stalled
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))

    // an empty result register never blocks the input side
    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)

    // a finished command is no longer busy
    `ASSERT_CLK(a_done_not_busy, i_clk, i_rst_n, o_out_valid |-> !(o_out_data.done_res && o_out_data.busy_res))

    // reset empties the result register
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind i2c_master_bit_sequencer_unit i2cms_checker u_i2cms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> verif/i2c_master_bit_sequencer_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit_checker
// watches the tick and line-state channels of the bit sequencer, runs a
// tick-accurate copy of the sequencer on every accepted input word and
// compares each result word field by field against the oldest prediction
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  i2cms_pkg::t_in_word              i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  i2cms_pkg::t_out_word             i_out_data,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [i2cms_pkg::CountWidth-1:0] i_cfg_data,
    output int                               o_fail_count,
    output int                               o_results_pending,
    output logic                             o_seq_busy,
    output int                               o_checked,
    output int                               o_done_seen
);
    import i2cms_pkg::*;

    // largest value the occupancy counter can hold
    localparam longint unsigned OccMax = (64'd1 << CountWidth) - 64'd1;

    // timing registers as last written
    logic [CountWidth-1:0] hold_cfg;
    logic [CountWidth-1:0] sample_cfg;

    // sequencer state
    t_op             cur_op;
    int unsigned     step_no;
    longint unsigned hold_left;
    logic [7:0]      shift_bits;
    logic [7:0]      rx_bits;
    logic            ack_bit;
    logic            scl_lvl;
    logic            sda_lvl;
    logic            seq_active;

    // predicted line-state words, oldest first
    t_out_word line_state_q[$];
    t_out_word predicted;

    int fails  = 0;
    int checked = 0;
    int dones  = 0;

    // number of line actions in each command
    function automatic int unsigned steps_of(input t_op op);
        int unsigned n;
        case (op)
            OP_START: n = 4;
            OP_STOP:  n = 3;
            OP_WRITE: n = 24;
            OP_READ:  n = 25;
            OP_SACK:  n = 3;
            default:  n = 4;
        endcase
        return n;
    endfunction

    // ticks a pin write occupies, zero hold behaves as one
    function automatic int unsigned pin_occ();
        return (hold_cfg == '0) ? 1 : int'(hold_cfg);
    endfunction

    // one line action of the running command, returns its occupancy
    task automatic line_action(input logic sda_now, output int unsigned occ);
        int unsigned ph;
        occ = pin_occ();
        case (cur_op)
            OP_START: begin
                case (step_no)
                    0:       sda_lvl = 1'b1;
                    1:       scl_lvl = 1'b1;
                    2:       sda_lvl = 1'b0;
                    default: scl_lvl = 1'b0;
                endcase
            end
            OP_STOP: begin
                case (step_no)
                    0:       sda_lvl = 1'b0;
                    1:       scl_lvl = 1'b1;
                    default: sda_lvl = 1'b1;
                endcase
            end
            OP_WRITE: begin
                ph = step_no % 3;
                if (ph == 0) begin
                    sda_lvl = shift_bits[7];
                end else if (ph == 1) begin
                    scl_lvl = 1'b1;
                end else begin
                    scl_lvl    = 1'b0;
                    shift_bits = {shift_bits[6:0], 1'b0};
                end
            end
            OP_READ: begin
                if (step_no == 0) begin
                    sda_lvl = 1'b1;
                end else begin
                    ph = (step_no - 1) % 3;
                    if (ph == 0) begin
                        scl_lvl = 1'b1;
                    end else if (ph == 1) begin
                        shift_bits = {shift_bits[6:0], sda_now};
                        occ        = 32'(sample_cfg);
                    end else begin
                        scl_lvl = 1'b0;
                    end
                end
            end
            OP_SACK: begin
                case (step_no)
                    0:       sda_lvl = shift_bits[7];
                    1:       scl_lvl = 1'b1;
                    default: scl_lvl = 1'b0;
                endcase
            end
            default: begin
                // receive ack
                case (step_no)
                    0: sda_lvl = 1'b1;
                    1: scl_lvl = 1'b1;
                    2: begin
                        ack_bit = sda_now;
                        occ     = 32'(sample_cfg);
                    end
                    default: scl_lvl = 1'b0;
                endcase
            end
        endcase
    endtask

    // one timing tick of the sequencer, gives the line-state word after it
    task automatic advance_sequencer(input t_in_word w, output t_out_word r);
        logic        run;
        logic        fin;
        logic        parked;
        int unsigned occ;
        run    = 1'b0;
        fin    = 1'b0;
        parked = 1'b0;
        if (!seq_active) begin
            if (w.cmd_valid && w.opcode <= OP_RACK) begin
                cur_op    = t_op'(w.opcode);
                step_no   = 0;
                hold_left = 0;
                case (cur_op)
                    OP_WRITE: shift_bits = w.tx_byte;
                    OP_SACK:  shift_bits = w.ack_level ? MsbMask : 8'h00;
                    default:  shift_bits = 8'h00;
                endcase
                seq_active = 1'b1;
                run        = 1'b1;
            end
        end else if (hold_left != 0) begin
            hold_left--;
        end else begin
            run = 1'b1;
        end
        // zero-occupancy samples fall through to the next action
        while (run && !parked && step_no < steps_of(cur_op)) begin
            line_action(w.sda_in, occ);
            step_no++;
            if (occ != 0) begin
                hold_left = 64'(occ - 1);
                if (hold_left > OccMax) hold_left = OccMax;
                parked = 1'b1;
            end
        end
        // completion on the tick the last occupancy runs out
        if (seq_active && hold_left == 0 && step_no >= steps_of(cur_op)) begin
            seq_active = 1'b0;
            fin        = 1'b1;
            if (cur_op == OP_READ) rx_bits = shift_bits;
        end
        r.scl_out  = scl_lvl;
        r.sda_out  = sda_lvl;
        r.busy_res = seq_active;
        r.done_res = fin;
        r.rx_byte  = rx_bits;
        r.ack_seen = ack_bit;
    endtask

    // compare one delivered word with the oldest prediction
    task automatic check_result(input t_out_word got);
        t_out_word want;
        if (got.done_res === 1'b1) dones++;
        if (line_state_q.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected result word %h, none predicted", got);
        end else begin
            want = line_state_q.pop_front();
            checked++;
            if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
                got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                got.rx_byte !== want.rx_byte || got.ack_seen !== want.ack_seen) begin
                fails++;
                if (fails <= 10) begin
                    $display("mismatch on word %0d: expected scl %b sda %b busy %b done %b rx %h ack %b",
                             checked, want.scl_out, want.sda_out, want.busy_res,
                             want.done_res, want.rx_byte, want.ack_seen);
                    $display("                  actual   scl %b sda %b busy %b done %b rx %h ack %b",
                             got.scl_out, got.sda_out, got.busy_res, got.done_res,
                             got.rx_byte, got.ack_seen);
                end
            end
        end
    endtask

    // track config writes, input words and result words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cfg   = HoldReset;
            sample_cfg = SampleReset;
            cur_op     = OP_START;
            step_no    = 0;
            hold_left  = 0;
            shift_bits = 8'h00;
            rx_bits    = 8'h00;
            ack_bit    = 1'b0;
            scl_lvl    = 1'b1;
            sda_lvl    = 1'b1;
            seq_active = 1'b0;
            line_state_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_HOLD) hold_cfg = i_cfg_data;
                else                       sample_cfg = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_in_valid && i_in_ready) begin
                advance_sequencer(i_in_data, predicted);
                line_state_q.push_back(predicted);
            end
        end
        o_fail_count      <= fails;
        o_results_pending <= line_state_q.size();
        o_seq_busy        <= seq_active;
        o_checked         <= checked;
        o_done_seen       <= dones;
    end

endmodule

>>> verif/i2c_master_bit_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit_tb
// drives tick words and timing writes into the bit sequencer: directed
// commands at short and long timing, then random command flows with random
// sender gaps and receiver stalls; the checker instance judges every word
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit_tb;
    import i2cms_pkg::*;

    // opcodes the sequencer must ignore
    localparam logic [2:0] OP_UNDEF_LO = 3'd6;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;

    localparam int IdleLimit = 5000;
    localparam int TailCycles = 8;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic                  i_cfg_idx   = REG_HOLD;
    logic [CountWidth-1:0] i_cfg_data  = '0;

    int   fail_count;
    int   results_pending;
    logic seq_busy;
    int   checked;
    int   done_seen;

    int  send_gap_pct   = 0;
    int  recv_stall_pct = 0;
    int  ticks_sent     = 0;
    int  idle_cycles    = 0;
    t_op flow_op        = OP_STOP;

    i2c_master_bit_sequencer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    i2c_master_bit_sequencer_unit_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_in_data         (i_in_data),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_out_data        (o_out_data),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_results_pending (results_pending),
        .o_seq_busy        (seq_busy),
        .o_checked         (checked),
        .o_done_seen       (done_seen)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // receiver side, random stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles where no word moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("timeout: no word moved for %0d cycles", IdleLimit);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one tick word with random don't-care fields
    function automatic t_in_word tick_word(input logic cmd, input logic [2:0] op,
                                           input int sda_mode);
        t_in_word w;
        w.cmd_valid = cmd;
        w.opcode    = op;
        w.tx_byte   = 8'($urandom);
        w.ack_level = 1'($urandom);
        w.sda_in    = (sda_mode == 2) ? 1'($urandom) : sda_mode[0];
        return w;
    endfunction

    // next command of a plausible bus transaction
    function automatic t_op flow_after(input t_op prev);
        t_op nxt;
        case (prev)
            OP_START: nxt = OP_WRITE;
            OP_WRITE: nxt = OP_RACK;
            OP_RACK: begin
                case ($urandom_range(3))
                    0:       nxt = OP_WRITE;
                    1:       nxt = OP_READ;
                    2:       nxt = OP_STOP;
                    default: nxt = OP_START;
                endcase
            end
            OP_READ:  nxt = OP_SACK;
            OP_SACK:  nxt = ($urandom_range(1) == 0) ? OP_READ : OP_STOP;
            default:  nxt = OP_START;
        endcase
        return nxt;
    endfunction

    // present one word, with an optional gap, and wait for its handshake
    task automatic push_word(input t_in_word w);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        ticks_sent++;
    endtask

    // issue a command, then further ticks (with random commands when noisy) until the sequencer is idle again
    task automatic run_cmd(input t_op op, input logic [7:0] tx, input logic ack,
                           input int sda_mode, input logic noisy);
        t_in_word w;
        w           = tick_word(1'b1, op, sda_mode);
        w.tx_byte   = tx;
        w.ack_level = ack;
        push_word(w);
        do begin
            w = tick_word(noisy && ($urandom_range(3) == 0), 3'($urandom_range(7)), sda_mode);
            push_word(w);
        end while (seq_busy);
    endtask

    // finish any running command, stop sending and drain all results
    task automatic settle();
        do begin
            push_word(tick_word(1'b0, OP_START, 2));
        end while (seq_busy);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CountWidth-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // new timing, written only once the sequencer is idle and drained
    task automatic set_timing(input logic [CountWidth-1:0] hold,
                              input logic [CountWidth-1:0] sample);
        settle();
        write_reg(REG_HOLD, hold);
        write_reg(REG_SAMPLE, sample);
        i_cfg_we <= 1'b0;
    endtask

    // short random timing, hold mostly one tick
    task automatic retime_random();
        logic [CountWidth-1:0] hold;
        case ($urandom_range(7))
            0:       hold = 0;
            1:       hold = 2;
            2:       hold = 3;
            default: hold = 1;
        endcase
        set_timing(hold, CountWidth'($urandom_range(2)));
    endtask

    // random ticks: mostly transaction-shaped commands, some noise
    task automatic random_ticks(input int count);
        t_in_word   w;
        logic       cmd;
        logic [2:0] op;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) retime_random();
            cmd = seq_busy ? ($urandom_range(99) < 12) : ($urandom_range(9) < 7);
            if (!seq_busy && cmd && $urandom_range(9) < 8) begin
                flow_op = flow_after(flow_op);
                op      = flow_op;
            end else if ($urandom_range(15) == 0) begin
                op = $urandom_range(1) ? OP_UNDEF_HI : OP_UNDEF_LO;
            end else begin
                op = 3'($urandom_range(int'(OP_RACK)));
            end
            w = tick_word(cmd, op, 2);
            push_word(w);
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset timing
        send_gap_pct   = 10;
        recv_stall_pct = 62;
        run_cmd(OP_START, 8'h00, 1'b0, 2, 1'b0);
        run_cmd(OP_RACK, 8'h00, 1'b0, 0, 1'b0);

        // zero hold and zero sample time
        set_timing('0, '0);
        run_cmd(OP_START, 8'h00, 1'b0, 2, 1'b0);
        run_cmd(OP_WRITE, 8'hFF, 1'b0, 2, 1'b0);
        run_cmd(OP_WRITE, 8'h00, 1'b1, 2, 1'b0);
        run_cmd(OP_WRITE, 8'hA5, 1'b0, 2, 1'b0);
        run_cmd(OP_READ, 8'h00, 1'b0, 1, 1'b0);
        run_cmd(OP_READ, 8'hFF, 1'b1, 0, 1'b0);
        run_cmd(OP_READ, 8'h5A, 1'b0, 2, 1'b0);
        run_cmd(OP_SACK, 8'h00, 1'b0, 2, 1'b0);
        run_cmd(OP_SACK, 8'hFF, 1'b1, 2, 1'b0);
        run_cmd(OP_RACK, 8'h00, 1'b0, 0, 1'b0);
        run_cmd(OP_RACK, 8'h00, 1'b0, 1, 1'b0);
        // undefined opcodes while idle
        push_word(tick_word(1'b1, OP_UNDEF_LO, 2));
        push_word(tick_word(1'b1, OP_UNDEF_HI, 2));
        run_cmd(OP_STOP, 8'h00, 1'b0, 2, 1'b0);
        // commands thrown at a busy sequencer
        run_cmd(OP_WRITE, 8'h3C, 1'b0, 2, 1'b1);

        // long hold, then long sample, without idling
        set_timing(16'd40, 16'd1);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        run_cmd(OP_STOP, 8'h00, 1'b0, 2, 1'b0);
        set_timing(16'd1, 16'd50);
        run_cmd(OP_RACK, 8'h00, 1'b0, 1, 1'b0);

        // random phases
        send_gap_pct   = 10;
        recv_stall_pct = 62;
        retime_random();
        random_ticks(180);
        send_gap_pct   = 62;
        recv_stall_pct = 10;
        retime_random();
        random_ticks(180);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        retime_random();
        random_ticks(180);

        // drain
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        $display("run covered %0d ticks: all six commands, undefined opcodes, busy-time commands",
                 ticks_sent);
        $display("%0d result words compared, %0d completions, hold and sample from 0 to 50",
                 checked, done_seen);
        if (results_pending != 0) $display("%0d predicted words never arrived", results_pending);
        if (fail_count == 0 && results_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/i2cms_pkg.sv
rtl/i2cms_action.sv
rtl/i2c_master_bit_sequencer_unit.sv
rtl/i2cms_checker.sv
verif/i2c_master_bit_sequencer_unit_checker.sv
verif/i2c_master_bit_sequencer_unit_tb.sv
